// ===== sv/cbps_pkg.sv =====
`default_nettype none

package cbps_pkg;

  // Field widths and limits of the sampler.
  localparam int COORD_W   = 24;
  localparam int SPACING_W = 23;
  localparam int STEPS_W   = 5;
  localparam int MAX_STEPS = 20;
  localparam int MIN_STEPS = 5;
  localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(410);

  // Curve parameter t is Q0.16 with one extra bit so that 1.0 fits.
  localparam int FRAC_W    = 16;
  localparam int T_W       = FRAC_W + 1;
  // Six times the basis weights use 6 * 2^16 = 3 * 2^17 as the divisor.
  localparam int DEN_SHIFT = FRAC_W + 1;

  // Queue between the classifier and the segment engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

  // What the back end has to do with one waypoint.
  typedef enum logic [1:0] {
    CMD_ERROR,
    CMD_FILL,
    CMD_SEGMENT,
    CMD_CLOSE
  } cmd_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } wp_item_t;

  typedef struct packed {
    logic               done;
    logic [STEPS_W-1:0] steps;
  } steps_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_COUNT,
    ST_DONE
  } len_state_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_START,
    BK_WAIT,
    BK_T2,
    BK_T3,
    BK_WGT,
    BK_PROD,
    BK_SUM,
    BK_DIV,
    BK_EMIT,
    BK_ERR
  } back_state_t;

  // Integer part of 65536 / steps: the per-sample increment of t.
  function automatic logic [FRAC_W-1:0] t_step_quot(input logic [STEPS_W-1:0] steps);
    logic [FRAC_W-1:0] q;
    case (steps)
      5'd5:    q = 16'd13107;
      5'd6:    q = 16'd10922;
      5'd7:    q = 16'd9362;
      5'd8:    q = 16'd8192;
      5'd9:    q = 16'd7281;
      5'd10:   q = 16'd6553;
      5'd11:   q = 16'd5957;
      5'd12:   q = 16'd5461;
      5'd13:   q = 16'd5041;
      5'd14:   q = 16'd4681;
      5'd15:   q = 16'd4369;
      5'd16:   q = 16'd4096;
      5'd17:   q = 16'd3855;
      5'd18:   q = 16'd3640;
      5'd19:   q = 16'd3449;
      5'd20:   q = 16'd3276;
      5'd21:   q = 16'd3120;
      default: q = '0;
    endcase
    return q;
  endfunction

  // Remainder of 131072 / (2 * steps), the fractional part of the increment.
  function automatic logic [STEPS_W:0] t_step_rem(input logic [STEPS_W-1:0] steps);
    logic [STEPS_W:0] r;
    case (steps)
      5'd5:    r = 6'd2;
      5'd6:    r = 6'd8;
      5'd7:    r = 6'd4;
      5'd8:    r = 6'd0;
      5'd9:    r = 6'd14;
      5'd10:   r = 6'd12;
      5'd11:   r = 6'd18;
      5'd12:   r = 6'd8;
      5'd13:   r = 6'd6;
      5'd14:   r = 6'd4;
      5'd15:   r = 6'd2;
      5'd16:   r = 6'd0;
      5'd17:   r = 6'd2;
      5'd18:   r = 6'd32;
      5'd19:   r = 6'd10;
      5'd20:   r = 6'd32;
      5'd21:   r = 6'd32;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cbps_front.sv =====
`default_nettype none

module cbps_front import cbps_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [COORD_W-1:0] in_x,
  input  wire logic signed [COORD_W-1:0] in_y,
  input  wire logic                      in_final,
  output logic                           push_valid,
  output wp_item_t                       push_item,
  input  wire logic                      push_ready
);

  logic [1:0] seen_r;
  logic [1:0] seen_nxt;
  cmd_t       cmd;

  // Classify the waypoint by how many points of the path came before it.
  always_comb begin
    if (in_final && (seen_r < 2'd2)) begin
      cmd      = CMD_ERROR;
      seen_nxt = 2'd0;
    end else if (seen_r == 2'd0) begin
      cmd      = CMD_FILL;
      seen_nxt = 2'd1;
    end else if (in_final) begin
      cmd      = CMD_CLOSE;
      seen_nxt = 2'd0;
    end else begin
      cmd      = CMD_SEGMENT;
      seen_nxt = (seen_r == 2'd3) ? 2'd3 : seen_r + 2'd1;
    end
  end

  assign in_ready       = push_ready;
  assign push_valid     = in_valid;
  assign push_item.cmd  = cmd;
  assign push_item.x    = in_x;
  assign push_item.y    = in_y;

  // Point count of the current path, saturating at three.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 2'd0;
    end else if (in_valid && push_ready) begin
      seen_r <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cbps_fifo.sv =====
`default_nettype none

module cbps_fifo import cbps_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push_valid,
  output logic          push_ready,
  input  wire wp_item_t push_item,
  output logic          pop_valid,
  output wp_item_t      pop_item,
  input  wire logic     pop
);

  wp_item_t                 mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_r;
  logic [QUEUE_PTR_W-1:0]   rd_ptr_r;
  logic [QUEUE_CNT_W-1:0]   count_r;
  logic                     do_push;
  logic                     do_pop;

  assign push_ready = (count_r != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cbps_steps.sv =====
`default_nettype none

module cbps_steps import cbps_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic signed [COORD_W:0]    dx,
  input  wire logic signed [COORD_W:0]    dy,
  input  wire logic [SPACING_W-1:0]       spacing,
  output steps_rsp_t                      rsp
);

  localparam int ROOT_W = COORD_W + 1;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int LEN_W  = ROOT_W + 1;
  localparam int ACC_W  = SPACING_W + STEPS_W;
  localparam int IT_W   = $clog2(ROOT_W);

  len_state_t          state_r;
  len_state_t          state_nxt;
  logic [COORD_W-1:0]  ax_r;
  logic [COORD_W-1:0]  ay_r;
  logic [RAD_W-1:0]    rad_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [IT_W-1:0]     it_r;
  logic [ACC_W-1:0]    acc_r;
  logic [STEPS_W-1:0]  q_r;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;
  logic                root_ge;
  logic [LEN_W-1:0]    len;
  logic                count_stop;

  // One root bit per cycle, then ceiling of the root, then the step count
  // found by stepping a multiple of the spacing up past the length.
  always_comb begin
    rem_sh     = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial      = {1'b0, root_r, 2'b01};
    root_ge    = (rem_sh >= trial);
    len        = LEN_W'(root_r) + LEN_W'(rem_r != '0);
    count_stop = (spacing == '0) || (acc_r >= ACC_W'(len)) ||
                 (q_r == STEPS_W'(MAX_STEPS));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_SQX;
      ST_SQX:   state_nxt = ST_SQY;
      ST_SQY:   state_nxt = ST_ROOT;
      ST_ROOT:  if (it_r == IT_W'(ROOT_W - 1)) state_nxt = ST_COUNT;
      ST_COUNT: if (count_stop) state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    rsp.done  = (state_r == ST_DONE);
    rsp.steps = (q_r < STEPS_W'(MIN_STEPS)) ? STEPS_W'(MIN_STEPS) : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ax_r <= dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
          ay_r <= dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
        end
      end
      ST_SQX: begin
        rad_r <= RAD_W'(ax_r) * RAD_W'(ax_r);
      end
      ST_SQY: begin
        rad_r  <= rad_r + RAD_W'(ay_r) * RAD_W'(ay_r);
        rem_r  <= '0;
        root_r <= '0;
        it_r   <= '0;
        acc_r  <= '0;
        q_r    <= '0;
      end
      ST_ROOT: begin
        rem_r  <= root_ge ? rem_sh - trial : rem_sh;
        root_r <= {root_r[ROOT_W-2:0], root_ge};
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        it_r   <= it_r + 1'b1;
      end
      ST_COUNT: begin
        if (count_stop) begin
          if (spacing == '0) q_r <= STEPS_W'(MAX_STEPS);
        end else begin
          q_r   <= q_r + 1'b1;
          acc_r <= acc_r + ACC_W'(spacing);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/cbps_back.sv =====
`default_nettype none

module cbps_back import cbps_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [SPACING_W-1:0]      spacing,
  input  wire logic                      q_valid,
  input  wire wp_item_t                  q_item,
  output logic                           q_pop,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [COORD_W-1:0]      out_sample_x,
  output logic signed [COORD_W-1:0]      out_sample_y,
  output logic [STEPS_W-1:0]             out_steps_in_segment,
  output logic                           out_first_in_segment,
  output logic                           out_last_sample,
  output logic                           out_status
);

  localparam int N_W      = T_W + 4;
  localparam int PROD_W   = N_W + COORD_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int DIV_W    = COORD_W + 4;
  localparam int RECIP_SH = COORD_W + 5;
  localparam int MUL_W    = DIV_W + RECIP_SH;
  localparam int TR_W     = STEPS_W + 2;
  localparam longint unsigned RECIP = ((64'd1 << RECIP_SH) + 64'd2) / 64'd3;
  localparam logic signed [N_W-1:0]   ONE_N      = N_W'(1 << FRAC_W);
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(3 << FRAC_W);
  localparam logic signed [SUM_W-1:0] OFFSET     = SUM_W'(3 << (COORD_W + 1));
  localparam logic signed [DIV_W:0]   BIAS       = (DIV_W + 1)'(1 << (COORD_W + 1));
  localparam logic signed [DIV_W:0]   CMAX       = (DIV_W + 1)'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [DIV_W:0]   CMIN       = -CMAX - 1;

  back_state_t               state_r;
  back_state_t               state_nxt;
  logic signed [COORD_W-1:0] win_r  [2][3];
  logic [1:0]                segs_left_r;
  logic [STEPS_W-1:0]        steps_r;
  logic [STEPS_W-1:0]        last_j_r;
  logic [STEPS_W-1:0]        j_r;
  logic [T_W-1:0]            t_r;
  logic [TR_W-1:0]           tr_r;
  logic [T_W-1:0]            t2_r;
  logic [T_W-1:0]            t3_r;
  logic signed [N_W-1:0]     n_r    [4];
  logic signed [PROD_W-1:0]  prod_r [2][4];
  logic [DIV_W-1:0]          dv_r   [2];
  logic signed [COORD_W-1:0] smp_r  [2];
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_x_r;
  logic signed [COORD_W-1:0] out_y_r;
  logic [STEPS_W-1:0]        out_steps_r;
  logic                      out_first_r;
  logic                      out_last_r;
  logic                      out_status_r;

  logic signed [COORD_W-1:0] ctl     [2][4];
  logic signed [N_W-1:0]     n_nxt   [4];
  logic signed [N_W-1:0]     ta;
  logic signed [N_W-1:0]     tb;
  logic signed [N_W-1:0]     tc;
  logic signed [SUM_W-1:0]   sum_c   [2];
  logic signed [SUM_W-1:0]   quo17   [2];
  logic [MUL_W-1:0]          mulq    [2];
  logic [DIV_W-1:0]          qv      [2];
  logic signed [DIV_W:0]     rv      [2];
  logic signed [COORD_W-1:0] sat_c   [2];
  logic [TR_W-1:0]           tr_sum;
  logic [TR_W-1:0]           tr_den;
  logic                      tr_carry;
  logic [T_W-1:0]            t_nxt;
  logic [TR_W-1:0]           tr_nxt;
  logic                      closing;
  logic                      out_free;
  logic                      seg_end;
  logic                      steps_start;
  logic                      out_load;
  logic signed [COORD_W:0]   seg_dx;
  logic signed [COORD_W:0]   seg_dy;
  steps_rsp_t                rsp;

  // Segment length and step count unit.
  assign seg_dx = (COORD_W + 1)'(win_r[0][2]) - (COORD_W + 1)'(win_r[0][1]);
  assign seg_dy = (COORD_W + 1)'(win_r[1][2]) - (COORD_W + 1)'(win_r[1][1]);

  cbps_steps u_steps (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (steps_start),
    .dx      (seg_dx),
    .dy      (seg_dy),
    .spacing (spacing),
    .rsp     (rsp)
  );

  assign closing  = (q_item.cmd == CMD_CLOSE) && (segs_left_r == 2'd1);
  assign out_free = !out_valid_r || out_ready;
  assign seg_end  = (j_r == last_j_r);

  // Control points of the segment: the window and the new waypoint.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ctl[0][k] = win_r[0][k];
      ctl[1][k] = win_r[1][k];
    end
    ctl[0][3] = q_item.x;
    ctl[1][3] = q_item.y;
  end

  // Basis weights, six times scaled, from t, t^2 and t^3.
  always_comb begin
    ta       = $signed(N_W'(t_r));
    tb       = $signed(N_W'(t2_r));
    tc       = $signed(N_W'(t3_r));
    n_nxt[0] = N_W'(-tc + 3 * tb - 3 * ta + ONE_N);
    n_nxt[1] = N_W'(3 * tc - 6 * tb + 4 * ONE_N);
    n_nxt[2] = N_W'(-3 * tc + 3 * tb + 3 * ta + ONE_N);
    n_nxt[3] = tc;
  end

  // Rounded floor division by 3 * 2^17: shift, then multiply by 1/3.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sum_c[a] = SUM_W'(prod_r[a][0]) + SUM_W'(prod_r[a][1]) + SUM_W'(prod_r[a][2]) +
                 SUM_W'(prod_r[a][3]) + ROUND_HALF;
      quo17[a] = (sum_c[a] >>> DEN_SHIFT) + OFFSET;
      mulq[a]  = MUL_W'(dv_r[a]) * MUL_W'(RECIP);
      qv[a]    = DIV_W'(mulq[a] >> RECIP_SH);
      rv[a]    = $signed({1'b0, qv[a]}) - BIAS;
      if (rv[a] > CMAX) begin
        sat_c[a] = COORD_W'(CMAX);
      end else if (rv[a] < CMIN) begin
        sat_c[a] = COORD_W'(CMIN);
      end else begin
        sat_c[a] = COORD_W'(rv[a]);
      end
    end
  end

  // Next t: add the quotient and carry the remainder modulo 2 * steps.
  always_comb begin
    tr_sum   = tr_r + TR_W'(t_step_rem(steps_r));
    tr_den   = TR_W'({steps_r, 1'b0});
    tr_carry = (tr_sum >= tr_den);
    t_nxt    = t_r + T_W'(t_step_quot(steps_r)) + T_W'(tr_carry);
    tr_nxt   = tr_carry ? tr_sum - tr_den : tr_sum;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          case (q_item.cmd)
            CMD_ERROR:   state_nxt = BK_ERR;
            CMD_FILL:    state_nxt = BK_IDLE;
            CMD_SEGMENT: state_nxt = BK_START;
            CMD_CLOSE:   state_nxt = BK_START;
            default:     state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_START: state_nxt = BK_WAIT;
      BK_WAIT:  if (rsp.done) state_nxt = BK_T2;
      BK_T2:    state_nxt = BK_T3;
      BK_T3:    state_nxt = BK_WGT;
      BK_WGT:   state_nxt = BK_PROD;
      BK_PROD:  state_nxt = BK_SUM;
      BK_SUM:   state_nxt = BK_DIV;
      BK_DIV:   state_nxt = BK_EMIT;
      BK_EMIT: begin
        if (out_free) begin
          if (!seg_end) begin
            state_nxt = BK_T2;
          end else if (segs_left_r == 2'd1) begin
            state_nxt = BK_IDLE;
          end else begin
            state_nxt = BK_START;
          end
        end
      end
      BK_ERR:   if (out_free) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    steps_start = (state_r == BK_START);
    out_load    = ((state_r == BK_EMIT) || (state_r == BK_ERR)) && out_free;
    q_pop       = ((state_r == BK_IDLE) && q_valid && (q_item.cmd == CMD_FILL)) ||
                  ((state_r == BK_ERR) && out_free) ||
                  ((state_r == BK_EMIT) && out_free && seg_end && (segs_left_r == 2'd1));
  end

  // State, output valid and the control point window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        for (int k = 0; k < 3; k++) begin
          win_r[a][k] <= '0;
        end
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == BK_IDLE) && q_valid && (q_item.cmd == CMD_FILL)) begin
        for (int k = 0; k < 3; k++) begin
          win_r[0][k] <= q_item.x;
          win_r[1][k] <= q_item.y;
        end
      end else if ((state_r == BK_ERR) && out_free) begin
        for (int a = 0; a < 2; a++) begin
          for (int k = 0; k < 3; k++) begin
            win_r[a][k] <= '0;
          end
        end
      end else if ((state_r == BK_EMIT) && out_free && seg_end) begin
        if ((segs_left_r == 2'd1) && (q_item.cmd == CMD_CLOSE)) begin
          for (int a = 0; a < 2; a++) begin
            for (int k = 0; k < 3; k++) begin
              win_r[a][k] <= '0;
            end
          end
        end else begin
          for (int a = 0; a < 2; a++) begin
            win_r[a][0] <= win_r[a][1];
            win_r[a][1] <= win_r[a][2];
            win_r[a][2] <= ctl[a][3];
          end
        end
      end
    end
  end

  // Sample datapath, one step per state.
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        segs_left_r <= (q_item.cmd == CMD_CLOSE) ? 2'd3 : 2'd1;
      end
      BK_WAIT: begin
        if (rsp.done) begin
          steps_r  <= rsp.steps;
          last_j_r <= closing ? rsp.steps : rsp.steps - 1'b1;
          j_r      <= '0;
          t_r      <= '0;
          tr_r     <= TR_W'(rsp.steps);
        end
      end
      BK_T2: begin
        t2_r <= T_W'(((2 * T_W)'(t_r) * (2 * T_W)'(t_r) + (2 * T_W)'(1 << (FRAC_W - 1)))
                     >> FRAC_W);
      end
      BK_T3: begin
        t3_r <= T_W'(((2 * T_W)'(t2_r) * (2 * T_W)'(t_r) + (2 * T_W)'(1 << (FRAC_W - 1)))
                     >> FRAC_W);
      end
      BK_WGT: begin
        for (int k = 0; k < 4; k++) begin
          n_r[k] <= n_nxt[k];
        end
      end
      BK_PROD: begin
        for (int a = 0; a < 2; a++) begin
          for (int k = 0; k < 4; k++) begin
            prod_r[a][k] <= PROD_W'(n_r[k]) * PROD_W'(ctl[a][k]);
          end
        end
      end
      BK_SUM: begin
        for (int a = 0; a < 2; a++) begin
          dv_r[a] <= DIV_W'(quo17[a]);
        end
      end
      BK_DIV: begin
        for (int a = 0; a < 2; a++) begin
          smp_r[a] <= sat_c[a];
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          out_x_r      <= smp_r[0];
          out_y_r      <= smp_r[1];
          out_steps_r  <= steps_r;
          out_first_r  <= (j_r == '0);
          out_last_r   <= seg_end && (segs_left_r == 2'd1);
          out_status_r <= 1'b0;
          if (seg_end) begin
            segs_left_r <= segs_left_r - 1'b1;
          end else begin
            j_r  <= j_r + 1'b1;
            t_r  <= t_nxt;
            tr_r <= tr_nxt;
          end
        end
      end
      BK_ERR: begin
        if (out_free) begin
          out_x_r      <= '0;
          out_y_r      <= '0;
          out_steps_r  <= '0;
          out_first_r  <= 1'b0;
          out_last_r   <= 1'b1;
          out_status_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_sample_x         = out_x_r;
  assign out_sample_y         = out_y_r;
  assign out_steps_in_segment = out_steps_r;
  assign out_first_in_segment = out_first_r;
  assign out_last_sample      = out_last_r;
  assign out_status           = out_status_r;

`ifndef SYNTH
  // An error result is always the only and last result of its item.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_last_r && (out_steps_r == '0)))
    else $error("error result with wrong shape");

  // The step count unit only reports counts inside the legal range.
  a_steps_range: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> ((rsp.steps >= STEPS_W'(MIN_STEPS)) && (rsp.steps <= STEPS_W'(MAX_STEPS))))
    else $error("step count out of range");

  // The sample index never passes the end of its segment.
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EMIT) |-> (j_r <= last_j_r))
    else $error("sample index beyond segment end");
`endif

endmodule

`default_nettype wire

// ===== sv/clamped_bspline_path_sampler_top.sv =====
`default_nettype none

// Clamped cubic B-spline path sampler.
// Waypoints enter on the in_ channel (valid/ready), one per item, with
// in_final_waypoint set on the last point of a path. Samples leave on the
// out_ channel (valid/ready); out_last_sample marks the last result of a
// waypoint, and a path of fewer than three points gives one result with
// out_status set. cfg_sample_spacing is written through the cfg_ channel,
// which is always ready; write it only while the block is idle.
// A two-entry queue sits behind the input, so waypoints are taken while the
// segment engine is busy. Each segment first runs the length unit: squaring
// of both offsets, a bit-serial square root and step counting. Each sample
// then passes through the blend datapath states (t^2, t^3, weights,
// products, sum, division, emit); a closing waypoint runs three segments.
// When out_ready is low the finished sample waits in the output register
// and the engine stalls; the queue keeps accepting until it is full.
// Reset clears the path, the queue and the output, and sets the spacing
// to 410 (0.1 in Q12.12).
module clamped_bspline_path_sampler_top import cbps_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [COORD_W-1:0] in_waypoint_x,
  input  wire logic signed [COORD_W-1:0] in_waypoint_y,
  input  wire logic                      in_final_waypoint,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [COORD_W-1:0]      out_sample_x,
  output logic signed [COORD_W-1:0]      out_sample_y,
  output logic [STEPS_W-1:0]             out_steps_in_segment,
  output logic                           out_first_in_segment,
  output logic                           out_last_sample,
  output logic                           out_status,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [SPACING_W-1:0]      cfg_sample_spacing
);

  logic [SPACING_W-1:0] spacing_r;
  logic                 push_valid;
  logic                 push_ready;
  wp_item_t             push_item;
  logic                 q_valid;
  wp_item_t             q_item;
  logic                 q_pop;

  // Spacing register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= SPACING_RESET;
    end else if (cfg_valid) begin
      spacing_r <= cfg_sample_spacing;
    end
  end

  cbps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_x       (in_waypoint_x),
    .in_y       (in_waypoint_y),
    .in_final   (in_final_waypoint),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  cbps_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  cbps_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .spacing              (spacing_r),
    .q_valid              (q_valid),
    .q_item               (q_item),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_sample_x         (out_sample_x),
    .out_sample_y         (out_sample_y),
    .out_steps_in_segment (out_steps_in_segment),
    .out_first_in_segment (out_first_in_segment),
    .out_last_sample      (out_last_sample),
    .out_status           (out_status)
  );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import cbps_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [STEPS_W-1:0]        steps;
    logic                      first;
    logic                      last;
    logic                      status;
  } sample_t;

  localparam longint ONE_Q16 = 65536;
  localparam longint COORD_HI = (64'sd1 <<< (COORD_W - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] in_waypoint_x = '0;
  logic signed [COORD_W-1:0] in_waypoint_y = '0;
  logic in_final_waypoint = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COORD_W-1:0] out_sample_x;
  logic signed [COORD_W-1:0] out_sample_y;
  logic [STEPS_W-1:0] out_steps_in_segment;
  logic out_first_in_segment;
  logic out_last_sample;
  logic out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SPACING_W-1:0] cfg_sample_spacing = '0;

  clamped_bspline_path_sampler_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_waypoint_x(in_waypoint_x), .in_waypoint_y(in_waypoint_y),
    .in_final_waypoint(in_final_waypoint),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sample_x(out_sample_x), .out_sample_y(out_sample_y),
    .out_steps_in_segment(out_steps_in_segment),
    .out_first_in_segment(out_first_in_segment),
    .out_last_sample(out_last_sample), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_sample_spacing(cfg_sample_spacing)
  );

  // Predictor state: a copy of the path window and the spacing register.
  longint win_x[3];
  longint win_y[3];
  int path_points;
  longint spacing;
  sample_t pending_samples[$];

  int mismatches = 0;
  int waypoints_sent = 0;
  int samples_checked = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_off = 0;
  int rx_wait = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Ceiling of the integer square root.
  function automatic longint unsigned root_ceil(longint unsigned v);
    longint unsigned rem, root, bitv;
    rem = v;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    if (root * root < v) root++;
    return root;
  endfunction

  function automatic int step_count();
    longint dx, dy, ax, ay, len, q;
    dx = win_x[2] - win_x[1];
    dy = win_y[2] - win_y[1];
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax >= (64'sd1 <<< 31) || ay >= (64'sd1 <<< 31) || spacing == 0) return MAX_STEPS;
    len = longint'(root_ceil(longint'(ax * ax + ay * ay)));
    q = (len + spacing - 1) / spacing;
    if (q < MIN_STEPS) q = MIN_STEPS;
    if (q > MAX_STEPS) q = MAX_STEPS;
    return int'(q);
  endfunction

  // Rounded, floored, saturated weighted sum of four control points.
  function automatic longint blend_point(longint n[4], longint p[4]);
    longint s, q, den;
    den = 6 * ONE_Q16;
    s = n[0] * p[0] + n[1] * p[1] + n[2] * p[2] + n[3] * p[3] + den / 2;
    q = s / den;
    if (s % den != 0 && s < 0) q--;
    if (q > COORD_HI) q = COORD_HI;
    if (q < COORD_LO) q = COORD_LO;
    return q;
  endfunction

  // Samples one segment closed by point (px,py), then shifts the window.
  task automatic sample_segment(longint px, longint py, bit closing);
    int steps, last_j;
    longint t, t2, t3;
    longint n[4], cx[4], cy[4];
    sample_t s;
    steps = step_count();
    last_j = closing ? steps : steps - 1;
    cx = '{win_x[0], win_x[1], win_x[2], px};
    cy = '{win_y[0], win_y[1], win_y[2], py};
    for (int j = 0; j <= last_j; j++) begin
      t = (j * 2 * ONE_Q16 + steps) / (2 * steps);
      t2 = (t * t + 32768) >>> 16;
      t3 = (t2 * t + 32768) >>> 16;
      n[0] = -t3 + 3 * t2 - 3 * t + ONE_Q16;
      n[1] = 3 * t3 - 6 * t2 + 4 * ONE_Q16;
      n[2] = -3 * t3 + 3 * t2 + 3 * t + ONE_Q16;
      n[3] = t3;
      s.x = COORD_W'(blend_point(n, cx));
      s.y = COORD_W'(blend_point(n, cy));
      s.steps = STEPS_W'(steps);
      s.first = (j == 0);
      s.last = 1'b0;
      s.status = 1'b0;
      pending_samples.insert(pending_samples.size(), s);
    end
    win_x = '{win_x[1], win_x[2], px};
    win_y = '{win_y[1], win_y[2], py};
  endtask

  task automatic clear_window();
    win_x = '{0, 0, 0};
    win_y = '{0, 0, 0};
    path_points = 0;
  endtask

  // Expected samples for one accepted waypoint.
  task automatic predict_waypoint(logic signed [COORD_W-1:0] x,
                                  logic signed [COORD_W-1:0] y, logic fin);
    int prior_count;
    longint px, py;
    sample_t s;
    prior_count = pending_samples.size();
    px = x;
    py = y;
    if (fin && path_points < 2) begin
      s = '{x: '0, y: '0, steps: '0, first: 1'b0, last: 1'b1, status: 1'b1};
      pending_samples.insert(pending_samples.size(), s);
      clear_window();
      return;
    end
    if (path_points == 0) begin
      win_x = '{px, px, px};
      win_y = '{py, py, py};
      path_points = 1;
      return;
    end
    sample_segment(px, py, 1'b0);
    if (path_points < 3) path_points++;
    if (fin) begin
      sample_segment(px, py, 1'b0);
      sample_segment(px, py, 1'b1);
      clear_window();
    end
    if (pending_samples.size() > prior_count)
      pending_samples[pending_samples.size() - 1].last = 1'b1;
  endtask

  // Offers one waypoint, after a random gap unless tx_idle is clear, and waits for it to be taken.
  task automatic send_waypoint(logic signed [COORD_W-1:0] x,
                               logic signed [COORD_W-1:0] y, logic fin);
    int gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_waypoint_x <= x;
    in_waypoint_y <= y;
    in_final_waypoint <= fin;
    do @(posedge clk); while (!in_ready);
    predict_waypoint(x, y, fin);
    waypoints_sent++;
  endtask

  task automatic end_stimulus();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every expected sample has come and the engine has drained.
  task automatic wait_drained();
    end_stimulus();
    wait (pending_samples.size() == 0);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_spacing(logic [SPACING_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_sample_spacing <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    spacing = v;
  endtask

  // Result checker and receiver stall control.
  always @(posedge clk) begin
    sample_t e;
    if (out_valid && out_ready) begin
      samples_checked++;
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample x=%0d y=%0d", out_sample_x,
                                       out_sample_y);
      end else begin
        e = pending_samples.pop_front();
        if (out_sample_x !== e.x || out_sample_y !== e.y ||
            out_steps_in_segment !== e.steps || out_first_in_segment !== e.first ||
            out_last_sample !== e.last || out_status !== e.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected x=%0d y=%0d steps=%0d first=%0b last=%0b st=%0b",
                     e.x, e.y, e.steps, e.first, e.last, e.status);
            $display("          got x=%0d y=%0d steps=%0d first=%0b last=%0b st=%0b",
                     out_sample_x, out_sample_y, out_steps_in_segment,
                     out_first_in_segment, out_last_sample, out_status);
          end
        end
      end
    end
    if (hold_off > 0) begin
      hold_off--;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= (rx_wait == 0);
    end else if (out_valid && out_ready && rx_idle) begin
      rx_wait = $urandom_range(0, 6);
      out_ready <= (rx_wait == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic signed [COORD_W-1:0] rand_coord();
    return COORD_W'($urandom);
  endfunction

  // Sends a path of n waypoints around a point, spread randomly within reach.
  task automatic send_path(int n, logic signed [COORD_W-1:0] cx,
                           logic signed [COORD_W-1:0] cy, int reach);
    longint x, y;
    for (int i = 0; i < n; i++) begin
      x = longint'(cx) + $signed($urandom_range(0, 2 * reach)) - reach;
      y = longint'(cy) + $signed($urandom_range(0, 2 * reach)) - reach;
      if (x > COORD_HI) x = COORD_HI;
      if (x < COORD_LO) x = COORD_LO;
      if (y > COORD_HI) y = COORD_HI;
      if (y < COORD_LO) y = COORD_LO;
      send_waypoint(COORD_W'(x), COORD_W'(y), i == n - 1);
    end
  endtask

  // Short paths, extreme coordinates, zero and huge segment lengths.
  task automatic test_directed();
    send_waypoint(24'sd100, -24'sd100, 1'b1);
    send_waypoint(24'sd5, 24'sd7, 1'b0);
    send_waypoint(24'sd9, 24'sd1, 1'b1);
    send_waypoint(24'sd0, 24'sd0, 1'b0);
    send_waypoint(24'sd4096, 24'sd0, 1'b0);
    send_waypoint(24'sd8192, 24'sd4096, 1'b1);
    send_waypoint(COORD_W'(COORD_HI), COORD_W'(COORD_HI), 1'b0);
    send_waypoint(COORD_W'(COORD_LO), COORD_W'(COORD_LO), 1'b0);
    send_waypoint(COORD_W'(COORD_HI), COORD_W'(COORD_LO), 1'b0);
    send_waypoint(COORD_W'(COORD_LO), COORD_W'(COORD_HI), 1'b1);
    send_waypoint(24'sd77, 24'sd77, 1'b0);
    send_waypoint(24'sd77, 24'sd77, 1'b0);
    send_waypoint(24'sd77, 24'sd77, 1'b1);
    send_waypoint(-24'sd1, -24'sd1, 1'b0);
    send_waypoint(24'sd1000, -24'sd3000, 1'b0);
    send_waypoint(24'sd1500, -24'sd2000, 1'b0);
    send_waypoint(24'sd0, 24'sd0, 1'b1);
  endtask

  // Random paths: mostly well formed, some short ones and wide jumps.
  task automatic test_random_paths(int items);
    int n, reach, pick;
    int sent;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 9);
      n = (pick == 0) ? $urandom_range(1, 2) : $urandom_range(3, 7);
      case ($urandom_range(0, 3))
        0: reach = 2000;
        1: reach = 8000;
        2: reach = 40000;
        default: reach = 1 << 23;
      endcase
      send_path(n, rand_coord(), rand_coord(), reach);
      sent += n;
    end
  endtask

  // Receiver holds off long enough for the input queue to fill up.
  task automatic test_backpressure();
    tx_idle = 1'b0;
    hold_off = 800;
    send_path(6, 24'sd0, 24'sd0, 6000);
    tx_idle = 1'b1;
  endtask

  // Runs of random paths without any idling on either side.
  task automatic test_no_idle(int items);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    test_random_paths(items);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    clear_window();
    spacing = SPACING_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_paths(50);
    write_spacing(SPACING_W'(1));
    test_directed();
    test_random_paths(25);
    write_spacing({SPACING_W{1'b1}});
    test_random_paths(25);
    write_spacing(SPACING_W'(1500));
    test_random_paths(40);
    test_backpressure();
    write_spacing(SPACING_W'(410));
    test_no_idle(25);
    test_random_paths(20);
    wait_drained();
    $display("%0d waypoints sent, %0d samples checked, %0d mismatches", waypoints_sent,
             samples_checked, mismatches);
    $display("covered short paths, extreme coordinates, four spacings and a long stall");
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== clamped_bspline_path_sampler_top.f =====
sv/cbps_pkg.sv
sv/cbps_front.sv
sv/cbps_fifo.sv
sv/cbps_steps.sv
sv/cbps_back.sv
sv/clamped_bspline_path_sampler_top.sv
sim/testbench.sv
